// ===== sv/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, codes and constants of the throughput credit controller.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int unsigned ElemInW   = 31;
  localparam int unsigned StampW    = 63;
  localparam int unsigned CycleW    = 40;
  localparam int unsigned CplxW     = 40;
  localparam int unsigned CreditW   = 32;
  localparam int unsigned BatchW    = 31;
  localparam int unsigned ElemTotW  = 48;
  localparam int unsigned TimeW     = 64;

  // multiplier: factor times one 16-bit slice of the element total per cycle
  localparam int unsigned SliceW    = 16;
  localparam int unsigned MulSteps  = ElemTotW / SliceW;
  localparam int unsigned PartW     = CplxW + SliceW;
  localparam int unsigned ProdW     = CplxW + ElemTotW;
  localparam int unsigned MulCntW   = $clog2(MulSteps);

  // divider: only the low quotient bits are developed, the rest is a clamp
  localparam int unsigned QuoW      = 31;
  localparam int unsigned DivSteps  = QuoW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);
  localparam int unsigned RemW      = TimeW - 1;

  localparam logic [CplxW-1:0]   CPLX_RESET   = CplxW'(50000);
  localparam logic [CreditW-1:0] INIT_CREDIT  = CreditW'(50);
  localparam logic [BatchW-1:0]  INIT_BATCH   = BatchW'(10);
  localparam logic [QuoW-1:0]    QUO_MAX      = {QuoW{1'b1}};
  localparam logic [QuoW-1:0]    QUO_MIN      = QuoW'(1);

  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_END     = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;
  localparam logic [1:0] FUNC_INIT    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_STORE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RES_INIT,
    RES_ONE,
    RES_NEG,
    RES_CALC
  } res_e;

  typedef struct packed {
    logic batch_start;
    logic batch_end;
    logic latch;
    logic mul_init;
    logic mul_step;
    logic div_check;
    logic div_step;
    logic store_quo;
    logic sel;
    logic out_load;
    logic clear_tot;
    res_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic busy_zero;
    logic busy_neg;
    logic mul_last;
    logic div_last;
    logic slot_free;
  } sts_t;

  localparam cmd_t CMD_NONE = '{
    batch_start: 1'b0,
    batch_end:   1'b0,
    latch:       1'b0,
    mul_init:    1'b0,
    mul_step:    1'b0,
    div_check:   1'b0,
    div_step:    1'b0,
    store_quo:   1'b0,
    sel:         1'b0,
    out_load:    1'b0,
    clear_tot:   1'b0,
    res_sel:     RES_INIT
  };

endpackage

// ===== sv/tcc_if.sv =====
// ----------------------------------------------------------------------------
// tcc_req_if / tcc_rsp_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tcc_req_if;
  import tcc_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [ElemInW-1:0]  batch_elements;
  logic [StampW-1:0]   timestamp_ns;
  logic [CycleW-1:0]   cycle_ns;

  modport source (output valid, func, batch_elements, timestamp_ns, cycle_ns,
                  input ready);
  modport sink   (input valid, func, batch_elements, timestamp_ns, cycle_ns,
                  output ready);
endinterface

interface tcc_rsp_if;
  import tcc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CreditW-1:0]  credit;
  logic [BatchW-1:0]   batch_len;

  modport source (output valid, credit, batch_len, input ready);
  modport sink   (input valid, credit, batch_len, output ready);
endinterface

// ===== sv/tcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcc_ctrl
// Sequencer: accepts beats, runs the two multiply/divide passes, issues result.
// ----------------------------------------------------------------------------
module tcc_ctrl
  import tcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic [1:0] func_i,
  input  sts_t       sts_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   sel_q, sel_d;
  res_e   res_q, res_d;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          sel_d = 1'b0;
          case (func_i)
            FUNC_COMPUTE: begin
              if (sts_i.busy_zero) begin
                res_d   = RES_ONE;
                state_d = ST_DONE;
              end else if (sts_i.busy_neg) begin
                res_d   = RES_NEG;
                state_d = ST_DONE;
              end else begin
                res_d   = RES_CALC;
                state_d = ST_MUL;
              end
            end
            FUNC_INIT: begin
              res_d   = RES_INIT;
              state_d = ST_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        if (sts_i.mul_last) state_d = ST_CHECK;
      end
      ST_CHECK: state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_last) state_d = ST_STORE;
      end
      ST_STORE: begin
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = ST_MUL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = CMD_NONE;
    cmd_o.sel     = sel_q;
    cmd_o.res_sel = res_q;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          case (func_i)
            FUNC_START:   cmd_o.batch_start = 1'b1;
            FUNC_END:     cmd_o.batch_end   = 1'b1;
            FUNC_COMPUTE: begin
              cmd_o.latch    = 1'b1;
              cmd_o.mul_init = !sts_i.busy_zero && !sts_i.busy_neg;
            end
            default: ;
          endcase
        end
      end
      ST_MUL:   cmd_o.mul_step  = 1'b1;
      ST_CHECK: cmd_o.div_check = 1'b1;
      ST_DIV:   cmd_o.div_step  = 1'b1;
      ST_STORE: begin
        cmd_o.store_quo = 1'b1;
        cmd_o.mul_init  = !sel_q;
      end
      ST_DONE: begin
        if (sts_i.slot_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.clear_tot = (res_q == RES_CALC) || (res_q == RES_NEG);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= 1'b0;
      res_q   <= RES_INIT;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      res_q   <= res_d;
    end
  end

endmodule

// ===== sv/tcc_dpath.sv =====
// ----------------------------------------------------------------------------
// tcc_dpath
// Totals, sliced multiplier, restoring divider with clamp, result register.
// ----------------------------------------------------------------------------
module tcc_dpath
  import tcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CplxW-1:0]    cfg_wdata_i,
  input  logic [ElemInW-1:0]  batch_elements_i,
  input  logic [StampW-1:0]   timestamp_ns_i,
  input  logic [CycleW-1:0]   cycle_ns_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [CreditW-1:0]  credit_o,
  output logic [BatchW-1:0]   batch_len_o
);

  logic [CplxW-1:0]    cplx_q;
  logic [ElemTotW-1:0] elem_q;
  logic [TimeW-1:0]    busy_q;
  logic [TimeW-1:0]    stamp_q;
  logic [CycleW-1:0]   cyc_q;

  logic [ProdW-1:0]    prod_q, prod_d;
  logic [MulCntW-1:0]  mcnt_q;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [QuoW-1:0]     quo_q, quo_d;
  logic [DivCntW-1:0]  dcnt_q;
  logic                over_q;
  logic [QuoW-1:0]     cq_q, bq_q;

  logic                out_valid_q;
  logic [CreditW-1:0]  credit_q;
  logic [BatchW-1:0]   batch_q;

  logic [CplxW-1:0]    factor;
  logic [SliceW-1:0]   slice;
  logic [PartW-1:0]    part;
  logic [RemW-1:0]     divisor;
  logic [RemW-1:0]     rem_init;
  logic [TimeW-1:0]    trial;
  logic                fits;
  logic                over;
  logic [QuoW-1:0]     quo_clamped;

  assign factor  = cmd_i.sel ? cplx_q : cyc_q;
  assign divisor = busy_q[RemW-1:0];

  // slices go most significant first, so the accumulator shifts left each step
  always_comb begin
    case (mcnt_q)
      2'd0:    slice = elem_q[3*SliceW-1:2*SliceW];
      2'd1:    slice = elem_q[2*SliceW-1:SliceW];
      default: slice = elem_q[SliceW-1:0];
    endcase
  end

  assign part = factor * slice;

  always_comb begin
    prod_d = prod_q;
    if (cmd_i.mul_init) begin
      prod_d = '0;
    end else if (cmd_i.mul_step) begin
      prod_d = {prod_q[ProdW-SliceW-1:0], {SliceW{1'b0}}}
             + {{(ProdW-PartW){1'b0}}, part};
    end else if (cmd_i.div_step) begin
      prod_d = {prod_q[ProdW-2:0], 1'b0};
    end
  end

  // quotient reaches 2^31 exactly when the product without its low bits
  // already covers the divisor
  assign rem_init = {{(RemW-(ProdW-QuoW)){1'b0}}, prod_q[ProdW-1:QuoW]};
  assign over     = rem_init >= divisor;
  assign trial    = {rem_q, prod_q[QuoW-1]};
  assign fits     = trial >= {1'b0, divisor};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.div_check) begin
      rem_d = rem_init;
      quo_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d = fits ? RemW'(trial - {1'b0, divisor}) : trial[RemW-1:0];
      quo_d = {quo_q[QuoW-2:0], fits};
    end
  end

  always_comb begin
    if (over_q) begin
      quo_clamped = QUO_MAX;
    end else if (quo_q == '0) begin
      quo_clamped = QUO_MIN;
    end else begin
      quo_clamped = quo_q;
    end
  end

  assign sts_o.busy_zero = (busy_q == '0);
  assign sts_o.busy_neg  = busy_q[TimeW-1];
  assign sts_o.mul_last  = (mcnt_q == MulCntW'(MulSteps - 1));
  assign sts_o.div_last  = (dcnt_q == DivCntW'(DivSteps - 1));
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cplx_q      <= CPLX_RESET;
      elem_q      <= '0;
      busy_q      <= '0;
      stamp_q     <= '0;
      mcnt_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cplx_q <= cfg_wdata_i;
      if (cmd_i.batch_start) begin
        elem_q  <= elem_q + {{(ElemTotW-ElemInW){1'b0}}, batch_elements_i};
        stamp_q <= {1'b0, timestamp_ns_i};
      end
      if (cmd_i.batch_end) begin
        busy_q <= busy_q + ({1'b0, timestamp_ns_i} - stamp_q);
      end
      if (cmd_i.clear_tot) begin
        elem_q <= '0;
        busy_q <= '0;
      end
      if (cmd_i.mul_init) begin
        mcnt_q <= '0;
      end else if (cmd_i.mul_step) begin
        mcnt_q <= mcnt_q + MulCntW'(1);
      end
      if (cmd_i.div_check) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + DivCntW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) cyc_q <= cycle_ns_i;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    if (cmd_i.div_check) over_q <= over;
    if (cmd_i.store_quo) begin
      if (cmd_i.sel) begin
        bq_q <= quo_clamped;
      end else begin
        cq_q <= quo_clamped;
      end
    end
    if (cmd_i.out_load) begin
      case (cmd_i.res_sel)
        RES_INIT: begin
          credit_q <= INIT_CREDIT;
          batch_q  <= INIT_BATCH;
        end
        RES_ONE: begin
          credit_q <= CreditW'(1);
          batch_q  <= BatchW'(1);
        end
        RES_NEG: begin
          credit_q <= CreditW'(2);
          batch_q  <= BatchW'(1);
        end
        default: begin
          credit_q <= {cq_q, 1'b0};
          batch_q  <= bq_q;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign credit_o    = credit_q;
  assign batch_len_o = batch_q;

endmodule

// ===== sv/throughput_credit_controller.sv =====
// ----------------------------------------------------------------------------
// throughput_credit_controller
// Element and busy-time bookkeeping with credit and batch-size grants.
// ----------------------------------------------------------------------------
// Batch-start and batch-end beats are absorbed in the cycle they are accepted.
// An initial grant, or a compute beat that finds the busy time zero or
// negative, goes straight to the done state, which loads the output register
// once that register is free; the input reopens after that load. A regular
// compute beat first develops two quotients, each through the 40x16 sliced
// multiplier, an overflow check, the shared one-bit-per-cycle restoring
// divider and a store step; then the done state loads the output register.
// A finished result waits in the output register; batch beats are still
// accepted while it waits, but a later grant keeps the input closed until
// the waiting result is taken.
module throughput_credit_controller
  import tcc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CplxW-1:0] cfg_wdata_i,
  tcc_req_if.sink          req_i,
  tcc_rsp_if.source        rsp_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign req_i.ready = in_ready;

  tcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (req_i.valid && in_ready),
    .func_i     (req_i.func),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  tcc_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .batch_elements_i (req_i.batch_elements),
    .timestamp_ns_i   (req_i.timestamp_ns),
    .cycle_ns_i       (req_i.cycle_ns),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (rsp_o.ready),
    .out_valid_o      (rsp_o.valid),
    .credit_o         (rsp_o.credit),
    .batch_len_o      (rsp_o.batch_len)
  );

endmodule

// ===== sv/tcc_checker.sv =====
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level properties of the throughput credit controller.
// ----------------------------------------------------------------------------
module tcc_checker
  import tcc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [1:0]         func_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [CreditW-1:0] credit_i,
  input logic [BatchW-1:0]  batch_len_i
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(credit_i) && $stable(batch_len_i))
    else $error("result beat changed while stalled");

  // grants are never zero
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (credit_i != '0) && (batch_len_i != '0))
    else $error("zero grant");

  // an odd credit only comes from the zero busy time answer
  a_odd_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && credit_i[0] |-> (credit_i == CreditW'(1)) &&
                                   (batch_len_i == BatchW'(1)))
    else $error("odd credit outside zero busy time case");

  // a beat that produces a result blocks the input for the next cycle
  a_busy_after_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (func_i == FUNC_COMPUTE || func_i == FUNC_INIT)
    |=> !in_ready_i)
    else $error("input accepted while a grant is in progress");

endmodule

bind throughput_credit_controller tcc_checker u_tcc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .func_i       (req_i.func),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .credit_i     (rsp_o.credit),
  .batch_len_i  (rsp_o.batch_len)
);
